// ===== src/slt_pkg.sv =====
// Shared types and constants for the source line tokenizer.
// No dependencies; every other file imports this package.
package slt_pkg;

   // Classified-word queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   // Token kinds
   localparam logic [4:0] KIND_STAR    = 5'd0;
   localparam logic [4:0] KIND_SLASH   = 5'd1;
   localparam logic [4:0] KIND_PLUS    = 5'd2;
   localparam logic [4:0] KIND_MINUS   = 5'd3;
   localparam logic [4:0] KIND_GT      = 5'd4;
   localparam logic [4:0] KIND_LT      = 5'd5;
   localparam logic [4:0] KIND_OR      = 5'd6;
   localparam logic [4:0] KIND_AND     = 5'd7;
   localparam logic [4:0] KIND_NEQ     = 5'd8;
   localparam logic [4:0] KIND_NOT     = 5'd9;
   localparam logic [4:0] KIND_EQEQ    = 5'd10;
   localparam logic [4:0] KIND_ASSIGN  = 5'd11;
   localparam logic [4:0] KIND_LPAREN  = 5'd12;
   localparam logic [4:0] KIND_RPAREN  = 5'd13;
   localparam logic [4:0] KIND_LBRACE  = 5'd14;
   localparam logic [4:0] KIND_RBRACE  = 5'd15;
   localparam logic [4:0] KIND_SEMI    = 5'd16;
   localparam logic [4:0] KIND_NUMBER  = 5'd17;
   localparam logic [4:0] KIND_LET     = 5'd18;
   localparam logic [4:0] KIND_IF      = 5'd19;
   localparam logic [4:0] KIND_ELSE    = 5'd20;
   localparam logic [4:0] KIND_PRINT   = 5'd21;
   localparam logic [4:0] KIND_PRINTLN = 5'd22;
   localparam logic [4:0] KIND_BOOL    = 5'd23;
   localparam logic [4:0] KIND_IDENT   = 5'd24;
   localparam logic [4:0] KIND_STRING  = 5'd25;
   localparam logic [4:0] KIND_END     = 5'd26;

   // Error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_BAR     = 3'd1;
   localparam logic [2:0] ERR_AMP     = 3'd2;
   localparam logic [2:0] ERR_UNKNOWN = 3'd3;
   localparam logic [2:0] ERR_DOT     = 3'd4;
   localparam logic [2:0] ERR_OPEN    = 3'd5;

   // Characters the back end compares against
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_PEND,
      MODE_WORD,
      MODE_NUM,
      MODE_STR,
      MODE_DROP
   } mode_type;

   typedef enum logic [2:0] {
      CLS_SINGLE,
      CLS_OPER,
      CLS_SPACE,
      CLS_ALPHA,
      CLS_DIGIT,
      CLS_QUOTE,
      CLS_DOT,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       line_end;
   } slt_req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [2:0]  error_code;
      logic        last_of_run;
   } slt_rsp_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       line_end;
      cls_type    cls;
      logic [4:0] single_kind;
   } slt_entry_type;

   // Match the first seven buffered letters of a word against the keywords
   function automatic logic [4:0] kw_match(input logic [6:0][7:0] p,
                                           input logic [15:0] cnt);
      logic [4:0] kind;
      kind = KIND_IDENT;
      if (cnt == 16'd3 && {p[0], p[1], p[2]} == "let") kind = KIND_LET;
      if (cnt == 16'd2 && {p[0], p[1]} == "if") kind = KIND_IF;
      if (cnt == 16'd4 && {p[0], p[1], p[2], p[3]} == "else") kind = KIND_ELSE;
      if (cnt == 16'd5 && {p[0], p[1], p[2], p[3], p[4]} == "print") kind = KIND_PRINT;
      if (cnt == 16'd7 && {p[0], p[1], p[2], p[3], p[4], p[5], p[6]} == "println")
         kind = KIND_PRINTLN;
      if (cnt == 16'd4 && {p[0], p[1], p[2], p[3]} == "true") kind = KIND_BOOL;
      if (cnt == 16'd5 && {p[0], p[1], p[2], p[3], p[4]} == "false") kind = KIND_BOOL;
      return kind;
   endfunction

endpackage

// ===== src/slt_front.sv =====
// Front end: classifies each incoming character word for the scanner.
// Depends on slt_pkg.
module slt_front
   import slt_pkg::*;
(
   input  slt_req_type   req_word,
   output slt_entry_type entry
);

   // Classify the byte and look up single-character operators
   always_comb begin
      logic [7:0] c;
      c = req_word.char_byte;
      entry.char_byte   = c;
      entry.line_end    = req_word.line_end;
      entry.single_kind = '0;
      entry.cls         = CLS_OTHER;
      case (c)
         8'h2A: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_STAR;   end
         8'h2F: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_SLASH;  end
         8'h2B: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_PLUS;   end
         8'h2D: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_MINUS;  end
         8'h3E: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_GT;     end
         8'h3C: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_LT;     end
         8'h28: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_LPAREN; end
         8'h29: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_RPAREN; end
         8'h7B: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_LBRACE; end
         8'h7D: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_RBRACE; end
         8'h3B: begin entry.cls = CLS_SINGLE; entry.single_kind = KIND_SEMI;   end
         CH_BAR, CH_AMP, CH_BANG, CH_EQ: begin
            entry.cls = CLS_OPER;
         end
         CH_QUOTE: begin
            entry.cls = CLS_QUOTE;
         end
         8'h2E: begin
            entry.cls = CLS_DOT;
         end
         default: begin
            if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
               entry.cls = CLS_SPACE;
            end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
               entry.cls = CLS_ALPHA;
            end else if (c >= 8'h30 && c <= 8'h39) begin
               entry.cls = CLS_DIGIT;
            end else begin
               entry.cls = CLS_OTHER;
            end
         end
      endcase
   end

endmodule

// ===== src/slt_queue.sv =====
// Short queue of classified words between front and back ends.
// Depends on slt_pkg.
module slt_queue
   import slt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  slt_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output slt_entry_type head_entry
);

   slt_entry_type       slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]       count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== src/slt_back.sv =====
// Back end: scanner state machine and result register.
// Depends on slt_pkg; fed by slt_queue.
module slt_back
   import slt_pkg::*;
#(
   parameter int MAX_LINE       = 65536,
   parameter int KEYWORD_BUFFER = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  slt_entry_type head_entry,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output slt_rsp_type   rsp_data
);

   localparam int PW  = $clog2(MAX_LINE);
   localparam int KIW = $clog2(KEYWORD_BUFFER);
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_LINE - 1);

   // Scanner state
   mode_type        mode_ff, mode_in;
   logic [7:0]      pend_op_ff, pend_op_in;
   logic            dot_seen_ff, dot_seen_in;
   logic [PW-1:0]   line_pos_ff, line_pos_in;
   logic [15:0]     tok_begin_ff, tok_begin_in;
   logic [15:0]     word_cnt_ff, word_cnt_in;
   logic [7:0]      word_prefix_ff [KEYWORD_BUFFER];

   // Prefix write for this word
   logic            pref_wr;
   logic [KIW-1:0]  pref_idx;
   logic [7:0]      pref_byte;

   // Results of the head word
   slt_rsp_type     res [3];
   logic [1:0]      res_cnt;

   // Output side
   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff;
   slt_rsp_type     rsp_data_ff;
   logic            can_load, at_last, load;
   slt_rsp_type     sel;

   function automatic slt_rsp_type mk(input logic [4:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic [2:0] err);
      slt_rsp_type r;
      r.token_kind   = kind;
      r.token_start  = start;
      r.token_length = len;
      r.error_code   = err;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   function automatic logic [15:0] inc_sat(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // Scan the head word: next state and the list of results
   always_comb begin
      logic [7:0]      c;
      logic            last;
      logic [15:0]     pos16;
      logic [15:0]     pos_next;
      logic [16:0]     pos_p1;
      logic            consumed;
      logic [2:0]      err;
      logic [1:0]      cnt;
      logic [6:0][7:0] cur7;
      logic [6:0][7:0] fin7;

      c        = head_entry.char_byte;
      last     = head_entry.line_end;
      pos16    = 16'(line_pos_ff);
      pos_p1   = {1'b0, pos16} + 17'd1;
      pos_next = pos_p1[16] ? 16'hFFFF : pos_p1[15:0];
      consumed = 1'b0;
      err      = ERR_NONE;
      cnt      = 2'd0;
      for (int i = 0; i < 3; i++) res[i] = '0;

      mode_in      = mode_ff;
      pend_op_in   = pend_op_ff;
      dot_seen_in  = dot_seen_ff;
      line_pos_in  = line_pos_ff;
      tok_begin_in = tok_begin_ff;
      word_cnt_in  = word_cnt_ff;
      pref_wr      = 1'b0;
      pref_idx     = word_cnt_ff[KIW-1:0];
      pref_byte    = c;

      for (int i = 0; i < 7; i++) cur7[i] = word_prefix_ff[i];

      if (mode_ff != MODE_DROP) begin
         // Finish the token in progress
         case (mode_ff)
            MODE_PEND: begin
               mode_in = MODE_IDLE;
               if (pend_op_ff == CH_BAR) begin
                  if (c == CH_BAR) begin
                     res[cnt] = mk(KIND_OR, tok_begin_ff, 16'd2, ERR_NONE);
                     cnt = cnt + 2'd1;
                     consumed = 1'b1;
                  end else begin
                     err = ERR_BAR;
                  end
               end else if (pend_op_ff == CH_AMP) begin
                  if (c == CH_AMP) begin
                     res[cnt] = mk(KIND_AND, tok_begin_ff, 16'd2, ERR_NONE);
                     cnt = cnt + 2'd1;
                     consumed = 1'b1;
                  end else begin
                     err = ERR_AMP;
                  end
               end else if (pend_op_ff == CH_BANG) begin
                  if (c == CH_EQ) begin
                     res[cnt] = mk(KIND_NEQ, tok_begin_ff, 16'd2, ERR_NONE);
                     consumed = 1'b1;
                  end else begin
                     res[cnt] = mk(KIND_NOT, tok_begin_ff, 16'd1, ERR_NONE);
                  end
                  cnt = cnt + 2'd1;
               end else begin
                  if (c == CH_EQ) begin
                     res[cnt] = mk(KIND_EQEQ, tok_begin_ff, 16'd2, ERR_NONE);
                     consumed = 1'b1;
                  end else begin
                     res[cnt] = mk(KIND_ASSIGN, tok_begin_ff, 16'd1, ERR_NONE);
                  end
                  cnt = cnt + 2'd1;
               end
            end
            MODE_WORD: begin
               if (head_entry.cls == CLS_ALPHA) begin
                  if (word_cnt_ff < 16'(KEYWORD_BUFFER)) pref_wr = 1'b1;
                  word_cnt_in = inc_sat(word_cnt_ff);
                  consumed = 1'b1;
               end else begin
                  res[cnt] = mk(kw_match(cur7, word_cnt_ff), tok_begin_ff, word_cnt_ff,
                                ERR_NONE);
                  cnt = cnt + 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_NUM: begin
               if (head_entry.cls == CLS_DIGIT) begin
                  word_cnt_in = inc_sat(word_cnt_ff);
                  consumed = 1'b1;
               end else if (head_entry.cls == CLS_DOT && !dot_seen_ff) begin
                  dot_seen_in = 1'b1;
                  word_cnt_in = inc_sat(word_cnt_ff);
                  consumed = 1'b1;
               end else if (head_entry.cls == CLS_DOT) begin
                  err = ERR_DOT;
               end else begin
                  res[cnt] = mk(KIND_NUMBER, tok_begin_ff, word_cnt_ff, ERR_NONE);
                  cnt = cnt + 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STR: begin
               consumed = 1'b1;
               if (head_entry.cls == CLS_QUOTE) begin
                  res[cnt] = mk(KIND_STRING, tok_begin_ff, word_cnt_ff, ERR_NONE);
                  cnt = cnt + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  word_cnt_in = inc_sat(word_cnt_ff);
               end
            end
            default: begin
            end
         endcase

         // Start a new token
         if (!consumed && err == ERR_NONE) begin
            case (head_entry.cls)
               CLS_SINGLE: begin
                  res[cnt] = mk(head_entry.single_kind, pos16, 16'd1, ERR_NONE);
                  cnt = cnt + 2'd1;
               end
               CLS_OPER: begin
                  mode_in      = MODE_PEND;
                  pend_op_in   = c;
                  tok_begin_in = pos16;
               end
               CLS_SPACE: begin
               end
               CLS_ALPHA: begin
                  mode_in      = MODE_WORD;
                  tok_begin_in = pos16;
                  word_cnt_in  = 16'd1;
                  pref_wr      = 1'b1;
                  pref_idx     = '0;
               end
               CLS_DIGIT: begin
                  mode_in      = MODE_NUM;
                  tok_begin_in = pos16;
                  word_cnt_in  = 16'd1;
                  dot_seen_in  = 1'b0;
               end
               CLS_QUOTE: begin
                  mode_in      = MODE_STR;
                  tok_begin_in = pos_next;
                  word_cnt_in  = 16'd0;
               end
               default: begin
                  err = ERR_UNKNOWN;
               end
            endcase
         end

         for (int i = 0; i < 7; i++) begin
            fin7[i] = (pref_wr && pref_idx == KIW'(i)) ? pref_byte : word_prefix_ff[i];
         end

         // Close the line
         if (last && err == ERR_NONE) begin
            if (mode_in == MODE_PEND || mode_in == MODE_STR) begin
               err = ERR_OPEN;
            end else begin
               if (mode_in == MODE_WORD) begin
                  res[cnt] = mk(kw_match(fin7, word_cnt_in), tok_begin_in, word_cnt_in,
                                ERR_NONE);
                  cnt = cnt + 2'd1;
               end else if (mode_in == MODE_NUM) begin
                  res[cnt] = mk(KIND_NUMBER, tok_begin_in, word_cnt_in, ERR_NONE);
                  cnt = cnt + 2'd1;
               end
               res[cnt] = mk(KIND_END, pos_next, 16'd0, ERR_NONE);
               cnt = cnt + 2'd1;
            end
         end

         // Report the first error and drop the rest of the line
         if (err != ERR_NONE) begin
            res[cnt] = mk(KIND_END, pos16, 16'd0, err);
            cnt = cnt + 2'd1;
            mode_in = MODE_DROP;
         end
      end else begin
         for (int i = 0; i < 7; i++) fin7[i] = word_prefix_ff[i];
      end

      // Track the line position
      if (last) begin
         mode_in     = MODE_IDLE;
         line_pos_in = '0;
      end else if (line_pos_ff < POS_MAX) begin
         line_pos_in = line_pos_ff + 1'b1;
      end

      res_cnt = cnt;
   end

   // Hand results to the output register one at a time
   always_comb begin
      can_load = !rsp_valid_ff || rsp_ready;
      at_last  = (res_cnt == 2'd0) || (idx_ff == res_cnt - 2'd1);
      load     = head_valid && (res_cnt != 2'd0) && can_load;
      pop      = head_valid && ((res_cnt == 2'd0) || (can_load && at_last));
      sel      = res[idx_ff];
      sel.last_of_run = at_last;
      if (pop) begin
         idx_in = 2'd0;
      end else if (load) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   // Commit scanner state when the head word retires
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         pend_op_ff   <= '0;
         dot_seen_ff  <= 1'b0;
         line_pos_ff  <= '0;
         tok_begin_ff <= '0;
         word_cnt_ff  <= '0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            mode_ff      <= mode_in;
            pend_op_ff   <= pend_op_in;
            dot_seen_ff  <= dot_seen_in;
            line_pos_ff  <= line_pos_in;
            tok_begin_ff <= tok_begin_in;
            word_cnt_ff  <= word_cnt_in;
         end
         idx_ff       <= idx_in;
         rsp_valid_ff <= load || (rsp_valid_ff && !rsp_ready);
      end
   end

   // Keyword buffer and result payload
   always_ff @(posedge clock) begin
      if (pop && pref_wr) word_prefix_ff[pref_idx] <= pref_byte;
      if (load) rsp_data_ff <= sel;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A partly emitted run always has its word still at the head
   a_idx_held: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> head_valid)
      else $error("result index advanced without a held word");

   // A dropped line yields nothing
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DROP) |-> !load)
      else $error("result loaded while dropping a line");

   // A word retires only after its final result
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |-> (res_cnt == 2'd0 || idx_ff == res_cnt - 2'd1))
      else $error("word retired before all results were sent");

   // Errors are carried only on end tokens
   a_err_end: assert property (@(posedge clock) disable iff (reset)
      (load && sel.error_code != ERR_NONE) |-> (sel.token_kind == KIND_END))
      else $error("error code on a non-end token");
`endif

endmodule

// ===== src/source_line_tokenizer_top.sv =====
// Top level of the source line tokenizer: front classifier, queue, scanner.
// Depends on slt_pkg, slt_front, slt_queue and slt_back.
//
//   channel  direction  payload        handshake
//   req_     in         slt_req_type   req_valid / req_ready
//   rsp_     out        slt_rsp_type   rsp_valid / rsp_ready
//
// One character word is taken per cycle while the four-entry queue has room.
// The scanner retires one word per cycle if it yields at most one token and
// the result register can load; a word with two or three tokens holds the
// scanner while they load in turn. A word passes a queue slot and the result
// register before rsp_valid rises. Synchronous reset clears the queue and
// scanner state; the keyword buffer holds no reset value. Either side may
// stall independently; a held result backs up the queue, then req_ready.
module source_line_tokenizer_top
   import slt_pkg::*;
#(
   parameter int MAX_LINE       = 65536,
   parameter int KEYWORD_BUFFER = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  slt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output slt_rsp_type rsp_data
);

   slt_entry_type front_entry;
   slt_entry_type head_entry;
   logic          q_full, head_valid, pop;

   assign req_ready = !q_full;

   slt_front u_front (
      .req_word (req_data),
      .entry    (front_entry)
   );

   slt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   slt_back #(
      .MAX_LINE       (MAX_LINE),
      .KEYWORD_BUFFER (KEYWORD_BUFFER)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
